>>> rtl/core/rucube_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rucube_pkg
// Shared widths, types and helpers for the ray / unit cube intersection unit.
// ----------------------------------------------------------------------------
package rucube_pkg;

	localparam int DATA_W        = 32;
	localparam int DIST_W        = 31;
	localparam int TOL_W         = 16;
	localparam int NUM_AXES      = 3;
	localparam int NUM_FACES     = 6;
	localparam int FRAC_BITS_DEF = 16;
	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(7);

	typedef logic signed [DATA_W-1:0] fix_t;

	typedef struct packed {
		logic              ok;
		logic [DIST_W-1:0] t;
	} cand_t;

	// Nearer of two face candidates; an invalid candidate never beats a valid one.
	function automatic cand_t cand_min(input cand_t a, input cand_t b);
		cand_t r;
		if (a.ok && (!b.ok || a.t <= b.t)) begin
			r = a;
		end else begin
			r = b;
		end
		return r;
	endfunction

endpackage

>>> rtl/core/ray_unit_cube_intersect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_unit_cube_intersect
// Ray against the axis-aligned unit cube centered at the origin.
// ----------------------------------------------------------------------------
// Takes one ray per unstalled clock (origin and direction, signed fixed point
// with FRAC_BITS fraction bits) and returns the smallest nonnegative ray
// parameter at which it hits a cube face, or hit = 0 with distance 0. Latency
// does not depend on FRAC_BITS and is set by the six restoring dividers that
// resolve one quotient bit per stage (one overflow stage plus 31 bit stages).
// The pipeline advances as a whole: when the output register holds a result
// that is stalled, in_stall rises. The user must write edge_tolerance through
// cfg_wr_en / cfg_wr_data only while idle; the block does not enforce this.
module ray_unit_cube_intersect
	import rucube_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [TOL_W-1:0]        cfg_wr_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [DATA_W-1:0] origin_x,
	input  logic signed [DATA_W-1:0] origin_y,
	input  logic signed [DATA_W-1:0] origin_z,
	input  logic signed [DATA_W-1:0] dir_x,
	input  logic signed [DATA_W-1:0] dir_y,
	input  logic signed [DATA_W-1:0] dir_z,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    hit,
	output logic [DIST_W-1:0]       distance
);

	localparam int NQ   = DIST_W;
	localparam int CW   = DATA_W + NQ;
	localparam int NW   = DATA_W + 2;
	localparam int PW   = 2 * DATA_W;
	localparam int SW   = PW + 1;
	localparam int NDV  = NQ + 2;
	localparam logic signed [NW-1:0] HALF_N = NW'(64'sd1 <<< (FRAC_BITS - 1));

	logic en;
	logic [TOL_W-1:0] tol_q;

	// stage 1: input capture
	logic v_s1;
	fix_t p_s1 [NUM_AXES];
	fix_t d_s1 [NUM_AXES];

	// divider chain: index 0 is the prep stage
	logic              dv_v   [NDV];
	fix_t              dv_p   [NDV][NUM_AXES];
	fix_t              dv_d   [NDV][NUM_AXES];
	logic [CW-1:0]     dv_rem [NDV][NUM_FACES];
	logic [DATA_W-1:0] dv_ud  [NDV][NUM_FACES];
	logic [NQ-1:0]     dv_q   [NDV][NUM_FACES];
	logic              dv_ok  [NDV][NUM_FACES];

	// multiply, bounds check, reduce
	logic                 v_sm;
	fix_t                 p_sm    [NUM_AXES];
	logic signed [PW-1:0] prod_sm [NUM_FACES][2];
	cand_t                c_sm    [NUM_FACES];
	logic                 v_sc;
	cand_t                c_sc    [NUM_FACES];
	logic                 v_sr1;
	cand_t                c_sr1   [3];
	logic                 v_sr2;
	cand_t                c_sr2   [2];

	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_wr_en) begin
			tol_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			dv_v[0]   <= 1'b0;
			v_sm      <= 1'b0;
			v_sc      <= 1'b0;
			v_sr1     <= 1'b0;
			v_sr2     <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			dv_v[0]   <= v_s1;
			v_sm      <= dv_v[NDV-1];
			v_sc      <= v_sm;
			v_sr1     <= v_sc;
			v_sr2     <= v_sr1;
			out_valid <= v_sr2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1[0] <= origin_x;
			p_s1[1] <= origin_y;
			p_s1[2] <= origin_z;
			d_s1[0] <= dir_x;
			d_s1[1] <= dir_y;
			d_s1[2] <= dir_z;
		end
	end

	// prep: numerator, magnitudes, sign and zero screening
	always_ff @(posedge clk) begin
		logic signed [NW-1:0] num;
		logic signed [NW-1:0] dx;
		logic [NW-1:0]        un;
		logic [NW-1:0]        ud;
		if (en) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				dv_p[0][a] <= p_s1[a];
				dv_d[0][a] <= d_s1[a];
			end
			for (int f = 0; f < NUM_FACES; f++) begin
				num = ((f % 2) == 0 ? HALF_N : -HALF_N) - NW'(p_s1[f / 2]);
				dx  = NW'(d_s1[f / 2]);
				un  = num[NW-1] ? NW'(-num) : NW'(num);
				ud  = dx[NW-1] ? NW'(-dx) : NW'(dx);
				dv_rem[0][f] <= CW'(un[DATA_W-1:0]) << FRAC_BITS;
				dv_ud[0][f]  <= ud[DATA_W-1:0];
				dv_q[0][f]   <= '0;
				dv_ok[0][f]  <= (dx != '0) && ((num == '0) || (num[NW-1] == dx[NW-1]));
			end
		end
	end

	for (genvar j = 0; j <= NQ; j++) begin : g_div
		localparam int B = NQ - j;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[j+1] <= 1'b0;
			end else if (en) begin
				dv_v[j+1] <= dv_v[j];
			end
		end

		always_ff @(posedge clk) begin
			logic [CW-1:0] sd;
			logic          ge;
			if (en) begin
				dv_p[j+1] <= dv_p[j];
				dv_d[j+1] <= dv_d[j];
				for (int f = 0; f < NUM_FACES; f++) begin
					sd = CW'(dv_ud[j][f]) << B;
					ge = dv_rem[j][f] >= sd;
					dv_ud[j+1][f] <= dv_ud[j][f];
					if (B == NQ) begin
						// quotient would not fit the distance field
						dv_rem[j+1][f] <= dv_rem[j][f];
						dv_q[j+1][f]   <= dv_q[j][f];
						dv_ok[j+1][f]  <= dv_ok[j][f] && !ge;
					end else begin
						dv_rem[j+1][f] <= ge ? (dv_rem[j][f] - sd) : dv_rem[j][f];
						dv_q[j+1][f]   <= dv_q[j][f] | (NQ'(ge) << B);
						dv_ok[j+1][f]  <= dv_ok[j][f];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_sm <= dv_p[NDV-1];
			for (int f = 0; f < NUM_FACES; f++) begin
				c_sm[f].ok <= dv_ok[NDV-1][f];
				c_sm[f].t  <= dv_q[NDV-1][f];
				for (int o = 0; o < 2; o++) begin
					prod_sm[f][o] <= $signed({1'b0, dv_q[NDV-1][f]})
						* dv_d[NDV-1][((f / 2) + o + 1) % NUM_AXES];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		logic signed [SW-1:0] pos;
		logic signed [SW-1:0] lim;
		logic                 inb;
		if (en) begin
			lim = SW'(HALF_N + NW'(tol_q)) <<< FRAC_BITS;
			for (int f = 0; f < NUM_FACES; f++) begin
				inb = 1'b1;
				for (int o = 0; o < 2; o++) begin
					pos = (SW'(p_sm[((f / 2) + o + 1) % NUM_AXES]) <<< FRAC_BITS)
						+ SW'(prod_sm[f][o]);
					if (pos > lim || pos < -lim) begin
						inb = 1'b0;
					end
				end
				c_sc[f].ok <= c_sm[f].ok && inb;
				c_sc[f].t  <= c_sm[f].t;
			end
		end
	end

	always_ff @(posedge clk) begin
		cand_t best;
		if (en) begin
			c_sr1[0] <= cand_min(c_sc[0], c_sc[1]);
			c_sr1[1] <= cand_min(c_sc[2], c_sc[3]);
			c_sr1[2] <= cand_min(c_sc[4], c_sc[5]);
			c_sr2[0] <= cand_min(c_sr1[0], c_sr1[1]);
			c_sr2[1] <= c_sr1[2];
			best      = cand_min(c_sr2[0], c_sr2[1]);
			hit      <= best.ok;
			distance <= best.ok ? best.t : '0;
		end
	end

endmodule

>>> rtl/core/rucube_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rucube_checker
// Port-level checks for the ray / unit cube intersection unit.
// ----------------------------------------------------------------------------
module rucube_checker
	import rucube_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic              hit,
	input logic [DIST_W-1:0] distance
);

	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("output valid after reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit) && $stable(distance))
		else $error("stalled result changed");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> distance == '0)
		else $error("miss with nonzero distance");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall not tied to output stall");

	a_no_transfer_lost: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> !(out_valid && out_stall))
		else $error("input accepted while output blocked");

endmodule

bind ray_unit_cube_intersect rucube_checker u_rucube_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.hit       (hit),
	.distance  (distance)
);

>>> dv/ray_unit_cube_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_unit_cube_checker
// Watches both channels of ray_unit_cube_intersect. It predicts each result
// from the accepted ray and the tracked edge_tolerance, then compares the
// results in order and counts the mismatches.
// ----------------------------------------------------------------------------
module ray_unit_cube_checker
	import rucube_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [TOL_W-1:0]  cfg_wr_data,
	input  logic              in_valid,
	input  logic              in_stall,
	input  fix_t              origin_x,
	input  fix_t              origin_y,
	input  fix_t              origin_z,
	input  fix_t              dir_x,
	input  fix_t              dir_y,
	input  fix_t              dir_z,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic              hit,
	input  logic [DIST_W-1:0] distance,
	output int                errors,
	output int                pending
);

	localparam int FRAC = FRAC_BITS_DEF;
	localparam longint unsigned DIST_MAX = 64'h7FFF_FFFF;

	typedef struct packed {
		logic              hit;
		logic [DIST_W-1:0] distance;
	} isect_t;

	isect_t            isect_q[$];
	logic [TOL_W-1:0]  tol;

	// Ray parameter for one face plane; returns 0 if the face is dropped.
	function automatic bit face_param(input longint num, input longint d, output longint t);
		longint unsigned un, ud, q;
		t = 0;
		if (d == 0) return 0;
		if (num == 0) return 1;
		if ((num < 0) != (d < 0)) return 0;
		un = (num < 0) ? -num : num;
		ud = (d < 0) ? -d : d;
		q = (un << FRAC) / ud;
		if (q > DIST_MAX) return 0;
		t = longint'(q);
		return 1;
	endfunction

	function automatic isect_t cube_isect(input fix_t o[3], input fix_t v[3],
			input logic [TOL_W-1:0] slack);
		longint half, bound, plane, t, pos, lim, best;
		bit found, ok;
		isect_t r;
		half = longint'(1) << (FRAC - 1);
		bound = half + longint'(slack);
		lim = bound << FRAC;
		found = 0;
		best = 0;
		for (int a = 0; a < 3; a++) begin
			for (int s = 0; s < 2; s++) begin
				plane = (s == 0) ? half : -half;
				if (face_param(plane - longint'(o[a]), longint'(v[a]), t)) begin
					ok = 1;
					for (int b = 0; b < 3; b++) begin
						if (b != a) begin
							pos = (longint'(o[b]) << FRAC) + t * longint'(v[b]);
							if (pos > lim || pos < -lim) ok = 0;
						end
					end
					if (ok && (!found || t < best)) begin
						best = t;
						found = 1;
					end
				end
			end
		end
		r.hit = found;
		r.distance = found ? best[DIST_W-1:0] : '0;
		return r;
	endfunction

	assign pending = isect_q.size();

	always @(posedge clk or negedge arst_n) begin
		fix_t o[3], v[3];
		isect_t want;
		if (!arst_n) begin
			tol <= TOL_RESET;
			errors <= 0;
			isect_q.delete();
		end else begin
			if (cfg_wr_en) tol <= cfg_wr_data;
			if (in_valid && !in_stall) begin
				o[0] = origin_x; o[1] = origin_y; o[2] = origin_z;
				v[0] = dir_x; v[1] = dir_y; v[2] = dir_z;
				isect_q.push_back(cube_isect(o, v, tol));
			end
			if (out_valid && !out_stall) begin
				if (isect_q.size() == 0) begin
					$display("%0t: unexpected transfer hit=%0b distance=%0h",
						$time, hit, distance);
					errors <= errors + 1;
				end else begin
					want = isect_q.pop_front();
					if (want.hit !== hit || want.distance !== distance) begin
						$display("%0t: mismatch expected hit=%0b distance=%0h, got hit=%0b distance=%0h",
							$time, want.hit, want.distance, hit, distance);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for ray_unit_cube_intersect: directed rays through faces, edges,
// corners and degenerate cases, then random aimed and raw rays over several
// edge_tolerance settings, with random idle and stall on both channels.
// ----------------------------------------------------------------------------
module tb;
	import rucube_pkg::*;

	localparam int LATENCY = 39;
	localparam int ONE = 65536;
	localparam int HALF = 32768;

	logic              clk = 0;
	logic              arst_n = 0;
	logic              cfg_wr_en = 0;
	logic [TOL_W-1:0]  cfg_wr_data = '0;
	logic              in_valid = 0;
	logic              in_stall;
	fix_t              origin_x = '0, origin_y = '0, origin_z = '0;
	fix_t              dir_x = '0, dir_y = '0, dir_z = '0;
	logic              out_valid;
	logic              out_stall = 0;
	logic              hit;
	logic [DIST_W-1:0] distance;
	int                errors, pending;
	bit                calm = 0;

	ray_unit_cube_intersect dut (.*);
	ray_unit_cube_checker chk (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	initial begin : stall_gen
		int n;
		forever begin
			@(posedge clk);
			n = idle_len();
			if (n == 0) begin
				out_stall <= 0;
			end else begin
				out_stall <= 1;
				repeat (n - 1) @(posedge clk);
			end
		end
	end

	task automatic send_ray(input fix_t ox, oy, oz, dx, dy, dz);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		origin_x <= ox; origin_y <= oy; origin_z <= oz;
		dir_x <= dx; dir_y <= dy; dir_z <= dz;
		in_valid <= 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic set_tol(input logic [TOL_W-1:0] v);
		drain();
		cfg_wr_en <= 1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 0;
	endtask

	function automatic fix_t rnd32();
		return fix_t'($urandom());
	endfunction

	task automatic random_rays(input int n);
		fix_t o[3], tg[3], v[3];
		int k;
		for (int i = 0; i < n; i++) begin
			if (i % 100 == 0) calm = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) < 7) begin
				// aimed at a point near the cube so that faces are hit
				for (int a = 0; a < 3; a++) begin
					o[a] = $signed($urandom_range(0, 6 * ONE)) - 3 * ONE;
					tg[a] = $signed($urandom_range(0, 3 * HALF)) - (3 * HALF) / 2;
					v[a] = tg[a] - o[a];
				end
				k = $urandom_range(0, 5);
				if (k == 0) v[$urandom_range(0, 2)] = 0;
				if (k == 1) o[$urandom_range(0, 2)] = ($urandom_range(0, 1)) ? HALF : -HALF;
				if (k == 2) for (int a = 0; a < 3; a++) v[a] = v[a] >>> $urandom_range(0, 12);
				send_ray(o[0], o[1], o[2], v[0], v[1], v[2]);
			end else begin
				send_ray(rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32());
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		calm = 1;
		send_ray(0, 0, -2 * ONE, 0, 0, ONE);
		send_ray(0, 0, 0, ONE, 0, 0);
		send_ray(0, 0, 0, 0, -ONE, 0);
		send_ray(HALF, 0, 0, ONE, 0, 0);
		send_ray(HALF, 0, 0, -ONE, 0, 0);
		send_ray(0, 0, 0, 0, 0, 0);
		send_ray(2 * ONE, 0, 0, ONE, 0, 0);
		send_ray(-2 * ONE, HALF, HALF, ONE, 0, 0);
		send_ray(-2 * ONE, HALF + 7, 0, ONE, 0, 0);
		send_ray(-2 * ONE, HALF + 8, 0, ONE, 0, 0);
		send_ray(-2 * ONE, -HALF - 7, -HALF - 7, ONE, 0, 0);
		send_ray(32'h8000_0000, 0, 0, 1, 0, 0);
		send_ray(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0);
		send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_ray(-ONE, -ONE, -ONE, ONE, ONE, ONE);
		send_ray(0, 0, -HALF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
		send_ray(-HALF, -HALF, -HALF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_ray(-3 * ONE, 0, 0, 1, 0, 0);
		calm = 0;
		random_rays(250);
		set_tol(16'd0);
		send_ray(-2 * ONE, HALF + 1, 0, ONE, 0, 0);
		send_ray(-2 * ONE, HALF, -HALF, ONE, 0, 0);
		random_rays(250);
		set_tol(16'hFFFF);
		send_ray(-2 * ONE, HALF + 65535, 0, ONE, 0, 0);
		send_ray(-2 * ONE, HALF + 65536, 0, ONE, 0, 0);
		random_rays(250);
		set_tol(16'($urandom()));
		random_rays(200);
		set_tol(TOL_RESET);
		random_rays(150);
		drain();
		if (errors == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("tb: errors");
		$finish;
	end

endmodule
